>>> rtl/rpip_pkg.sv
package rpip_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int RESULT_WIDTH = 64;
    localparam int PROD_WIDTH   = VALUE_WIDTH + 4;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;
    localparam logic [3:0] MAX_BIN_DIGIT = 4'd1;
    localparam logic [3:0] MAX_OCT_DIGIT = 4'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DROP
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    // Bit 4 is set when the character is not a hexadecimal digit at all.
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = ch - CH_ZERO;
        end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
            d = ch - CH_LOW_A + 8'd10;
        end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
            d = ch - CH_UP_A + 8'd10;
        end else begin
            d = 8'h10;
        end
        return d[4:0];
    endfunction

    function automatic logic digit_fits(input logic [4:0] hd, input t_radix radix);
        logic fits;
        case (radix)
            RADIX_DEC: fits = !hd[4] && (hd[3:0] <= MAX_DEC_DIGIT);
            RADIX_BIN: fits = !hd[4] && (hd[3:0] <= MAX_BIN_DIGIT);
            RADIX_OCT: fits = !hd[4] && (hd[3:0] <= MAX_OCT_DIGIT);
            RADIX_HEX: fits = !hd[4];
            default:   fits = 1'b0;
        endcase
        return fits;
    endfunction

endpackage

>>> rtl/rpip_char_if.sv
interface rpip_char_if ();
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

>>> rtl/rpip_result_if.sv
interface rpip_result_if import rpip_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [RESULT_WIDTH-1:0] value;
    logic [1:0]                     radix_code;
    logic [1:0]                     status;

    modport source (output valid, output value, output radix_code, output status, input ready);
    modport sink   (input valid, input value, input radix_code, input status, output ready);
endinterface

>>> rtl/rpip_mac.sv
module rpip_mac import rpip_pkg::*; (
    input  logic [VALUE_WIDTH-1:0] i_acc,
    input  t_radix                 i_radix,
    input  logic [3:0]             i_digit,
    input  logic                   i_minus,
    output logic [VALUE_WIDTH-1:0] o_acc,
    output logic                   o_over
);

    logic [PROD_WIDTH-1:0] w_ext;
    logic [PROD_WIDTH-1:0] w_prod;
    logic [PROD_WIDTH-1:0] w_sum;
    logic [PROD_WIDTH-1:0] w_limit;

    // The magnitude may reach 2^(VALUE_WIDTH-1) only when a minus sign was seen.
    assign w_ext   = PROD_WIDTH'(i_acc);
    assign w_limit = PROD_WIDTH'({1'b1, {(VALUE_WIDTH-1){1'b0}}})
                   - {{(PROD_WIDTH-1){1'b0}}, ~i_minus};

    always_comb begin
        case (i_radix)
            RADIX_DEC: w_prod = (w_ext << 3) + (w_ext << 1);
            RADIX_BIN: w_prod = w_ext << 1;
            RADIX_OCT: w_prod = w_ext << 3;
            RADIX_HEX: w_prod = w_ext << 4;
            default:   w_prod = w_ext;
        endcase
    end

    assign w_sum  = w_prod + {{(PROD_WIDTH-4){1'b0}}, i_digit};
    assign o_over = w_sum > w_limit;
    assign o_acc  = w_sum[VALUE_WIDTH-1:0];

endmodule

>>> rtl/radix_prefixed_integer_parser_top.sv
// Flow: an accepted item is held in the input register, and its result, if
// any, is written to the result register when the item leaves the input register.
// Throughput: one character item per cycle while results are not held back;
// the token state update is a single constant-base multiply-add and compare
// per character. Reset (synchronous, active low) empties both registers and
// returns the parser to idle with a cleared token.
module radix_prefixed_integer_parser_top import rpip_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rpip_char_if.sink      i_char,
    rpip_result_if.source  o_result
);

    logic       r_in_valid;
    logic [7:0] r_char;

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_minus, n_minus;
    logic                   r_ovf, n_ovf;
    logic                   r_dseen, n_dseen;
    t_radix                 r_radix, n_radix;

    logic                           r_out_valid;
    logic signed [RESULT_WIDTH-1:0] r_out_value;
    t_radix                         r_out_radix;
    t_status                        r_out_status;

    logic                           w_can;
    logic                           w_adv;
    logic                           w_space;
    logic [4:0]                     w_hd;
    t_radix                         w_mac_radix;
    logic [VALUE_WIDTH-1:0]         w_mac_acc;
    logic                           w_mac_over;
    logic signed [VALUE_WIDTH-1:0]  w_signed;
    logic                           w_emit;
    logic signed [RESULT_WIDTH-1:0] w_emit_value;
    t_radix                         w_emit_radix;
    t_status                        w_emit_status;
    logic                           do_bad_now;

    assign w_can        = !r_out_valid || o_result.ready;
    assign w_adv        = r_in_valid && w_can;
    assign i_char.ready = !r_in_valid || w_can;

    assign w_space     = is_space(r_char);
    assign w_hd        = hex_digit(r_char);
    assign w_mac_radix = (r_phase == PH_ZERO) ? RADIX_OCT : r_radix;
    assign w_signed    = r_minus ? signed'(-r_acc) : signed'(r_acc);
    assign do_bad_now  = !digit_fits(w_hd, r_radix);

    rpip_mac u_mac (
        .i_acc   (r_acc),
        .i_radix (w_mac_radix),
        .i_digit (w_hd[3:0]),
        .i_minus (r_minus),
        .o_acc   (w_mac_acc),
        .o_over  (w_mac_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_ovf   <= 1'b0;
            r_dseen <= 1'b0;
            r_radix <= RADIX_DEC;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_ovf   <= n_ovf;
            r_dseen <= n_dseen;
            r_radix <= n_radix;
        end
    end

    always_comb begin
        logic do_clear;
        logic do_add;
        logic do_bad;
        t_radix bad_radix;

        do_clear      = 1'b0;
        do_add        = 1'b0;
        do_bad        = 1'b0;
        bad_radix     = r_radix;
        n_phase       = r_phase;
        n_radix       = r_radix;
        n_minus       = r_minus;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_radix  = r_radix;
        w_emit_status = ST_OK;

        case (r_phase)
            PH_SIGN: begin
                if (w_space) begin
                    do_clear      = 1'b1;
                    n_phase       = PH_IDLE;
                    w_emit        = 1'b1;
                    w_emit_radix  = RADIX_DEC;
                    w_emit_status = ST_EMPTY;
                end else if (r_char == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (r_char >= CH_ONE && r_char <= CH_NINE) begin
                    n_radix = RADIX_DEC;
                    do_add  = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_ZERO: begin
                if (w_space) begin
                    do_clear      = 1'b1;
                    n_phase       = PH_IDLE;
                    w_emit        = 1'b1;
                    w_emit_radix  = RADIX_OCT;
                    w_emit_status = ST_OK;
                end else if (r_char == CH_LOW_B) begin
                    n_radix = RADIX_BIN;
                    n_phase = PH_DIGITS;
                end else if (r_char == CH_LOW_X) begin
                    n_radix = RADIX_HEX;
                    n_phase = PH_DIGITS;
                end else if (digit_fits(w_hd, RADIX_OCT)) begin
                    n_radix = RADIX_OCT;
                    do_add  = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    do_bad    = 1'b1;
                    bad_radix = RADIX_OCT;
                end
            end
            PH_DIGITS: begin
                if (w_space) begin
                    do_clear     = 1'b1;
                    n_phase      = PH_IDLE;
                    w_emit       = 1'b1;
                    w_emit_radix = r_radix;
                    if (!r_dseen) begin
                        w_emit_status = ST_EMPTY;
                    end else if (r_ovf) begin
                        w_emit_status = ST_OVERFLOW;
                    end else begin
                        w_emit_status = ST_OK;
                        w_emit_value  = RESULT_WIDTH'(w_signed);
                    end
                end else if (digit_fits(w_hd, r_radix)) begin
                    do_add = 1'b1;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_DROP: begin
                if (w_space) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                do_clear = 1'b1;
                n_phase  = PH_IDLE;
                if (w_space) begin
                    n_phase = PH_IDLE;
                end else if (r_char == CH_MINUS) begin
                    n_phase = PH_SIGN;
                end else if (r_char == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (r_char >= CH_ONE && r_char <= CH_NINE) begin
                    do_add  = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    do_bad    = 1'b1;
                    bad_radix = RADIX_DEC;
                end
            end
        endcase

        if (do_bad) begin
            do_clear      = 1'b1;
            n_phase       = PH_DROP;
            w_emit        = 1'b1;
            w_emit_value  = '0;
            w_emit_radix  = bad_radix;
            w_emit_status = ST_BAD;
        end

        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_dseen = r_dseen;
        if (do_clear) begin
            n_acc   = '0;
            n_minus = 1'b0;
            n_ovf   = 1'b0;
            n_dseen = 1'b0;
            n_radix = RADIX_DEC;
        end
        if (do_add) begin
            n_dseen = 1'b1;
            if (!r_ovf) begin
                if (w_mac_over) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_mac_acc;
                end
            end
        end
        if (r_phase == PH_IDLE && !w_space && r_char == CH_MINUS) begin
            n_minus = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_can) begin
            r_out_valid <= r_in_valid && w_emit;
        end
        if (w_adv && w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_radix  <= w_emit_radix;
            r_out_status <= w_emit_status;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.value      = r_out_value;
    assign o_result.radix_code = r_out_radix;
    assign o_result.status     = r_out_status;

`ifndef NO_ASSERTIONS
    a_idle_token_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_DROP) |->
            (r_acc == '0 && !r_minus && !r_ovf && !r_dseen))
        else $error("Token state not cleared outside a token.");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_can) |=> (r_in_valid && $stable(r_char)))
        else $error("Waiting input item lost or changed.");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_ovf && r_phase == PH_DIGITS && !w_space && !do_bad_now) |=> r_ovf)
        else $error("Overflow flag dropped inside a token.");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_emit_status != ST_OK) |=> (r_out_value == '0))
        else $error("Failed token gave a non-zero value.");
`endif

endmodule
